// ----- rtl/core/tckd_pkg.sv -----
`default_nettype none
package tckd_pkg;

   // config register indexes
   localparam logic [2:0] CSR_STEP_SIZE     = 3'd0;
   localparam logic [2:0] CSR_TURN_FLOOR    = 3'd1;
   localparam logic [2:0] CSR_SHORT_LIMIT   = 3'd2;
   localparam logic [2:0] CSR_LONG_MIN      = 3'd3;
   localparam logic [2:0] CSR_SETUP_MIN     = 3'd4;

   localparam logic [6:0]  STEP_SIZE_RST    = 7'd5;
   localparam logic [7:0]  TURN_FLOOR_RST   = 8'd15;
   localparam logic [15:0] SHORT_LIMIT_RST  = 16'd500;
   localparam logic [15:0] LONG_MIN_RST     = 16'd1500;
   localparam logic [15:0] SETUP_MIN_RST    = 16'd5000;

   localparam logic [7:0]  LEVEL_RST        = 8'd128;
   localparam logic [7:0]  LEVEL_MAX        = 8'd255;
   localparam logic [15:0] PRESS_MAX        = 16'hFFFF;

   typedef enum logic [1:0] {
      PRESET_WARM  = 2'd0,
      PRESET_MIXED = 2'd1,
      PRESET_WHITE = 2'd2
   } preset_type;

   typedef struct packed {
      logic [7:0] a;
      logic [7:0] b;
   } level_pair_type;

   function automatic preset_type next_preset(input preset_type p);
      preset_type n;
      case (p)
         PRESET_WARM:  n = PRESET_MIXED;
         PRESET_MIXED: n = PRESET_WHITE;
         PRESET_WHITE: n = PRESET_WARM;
         default:      n = PRESET_WARM;
      endcase
      return n;
   endfunction

   function automatic level_pair_type preset_levels(input preset_type p);
      level_pair_type l;
      case (p)
         PRESET_WARM:  l = '{a: 8'd255, b: 8'd0};
         PRESET_MIXED: l = '{a: 8'd255, b: 8'd255};
         PRESET_WHITE: l = '{a: 8'd0,   b: 8'd255};
         default:      l = '{a: 8'd255, b: 8'd0};
      endcase
      return l;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/two_channel_knob_dimmer_unit.sv -----
`default_nettype none
// Latency: a result word is valid the cycle after its request word is taken.
// Throughput: one word per cycle; all tick logic sits between the state
// registers and the result register, and req_stall only rises while a
// held result is stalled downstream.
// Reset (synchronous): config back to defaults, levels 128, duties 0, light on,
// warm preset, press timer cleared, no result pending.
module two_channel_knob_dimmer_unit
   import tckd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write,
   input  wire logic [2:0]        csr_index,
   input  wire logic [15:0]       csr_wdata,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic signed [1:0] req_turn_dir,
   input  wire logic              req_button_down,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [7:0]             rsp_duty_a,
   output logic [7:0]             rsp_duty_b,
   output logic                   rsp_light_on,
   output logic                   rsp_setup_request
);

   logic [6:0]  step_size_ff;
   logic [7:0]  turn_floor_ff;
   logic [15:0] short_limit_ff, long_min_ff, setup_min_ff;

   logic [7:0]  level_a_ff, level_a_in, level_b_ff, level_b_in;
   logic [7:0]  out_a_ff, out_a_in, out_b_ff, out_b_in;
   logic        on_ff, on_in;
   preset_type  preset_ff, preset_in;
   logic [15:0] press_ff, press_in;
   logic        prev_btn_ff;
   logic        setup_ff, setup_in;
   logic        rsp_valid_ff;

   logic           accept;
   logic           up, down;
   level_pair_type preset_lv;

   function automatic logic [7:0] sat_add(input logic [7:0] v, input logic [6:0] s);
      logic [8:0] t;
      t = {1'b0, v} + {2'b00, s};
      return t[8] ? LEVEL_MAX : t[7:0];
   endfunction

   // subtract, floored at lo
   function automatic logic [7:0] sat_sub(input logic [7:0] v, input logic [6:0] s,
                                          input logic [7:0] lo);
      logic signed [9:0] t;
      t = $signed({2'b00, v}) - $signed({3'b000, s});
      return (t < $signed({2'b00, lo})) ? lo : t[7:0];
   endfunction

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign up   = (req_turn_dir == 2'sb01);
   assign down = req_turn_dir[1];

   always_comb begin
      level_a_in = level_a_ff;
      level_b_in = level_b_ff;
      out_a_in   = out_a_ff;
      out_b_in   = out_b_ff;
      on_in      = on_ff;
      preset_in  = preset_ff;
      press_in   = press_ff;
      setup_in   = 1'b0;
      preset_lv  = preset_levels(next_preset(preset_ff));

      // knob turn first
      if (up || down) begin
         if (!req_button_down) begin
            // normal turn is gated on channel A only
            if (up && level_a_ff != LEVEL_MAX) begin
               level_a_in = sat_add(level_a_ff, step_size_ff);
               level_b_in = sat_add(level_b_ff, step_size_ff);
            end else if (down && level_a_ff > turn_floor_ff) begin
               level_a_in = sat_sub(level_a_ff, step_size_ff, turn_floor_ff);
               level_b_in = sat_sub(level_b_ff, step_size_ff, turn_floor_ff);
            end
         end else if (up) begin
            level_a_in = sat_sub(level_a_ff, step_size_ff, 8'd0);
            level_b_in = sat_add(level_b_ff, step_size_ff);
         end else begin
            level_a_in = sat_add(level_a_ff, step_size_ff);
            level_b_in = sat_sub(level_b_ff, step_size_ff, 8'd0);
         end
         out_a_in = level_a_in;
         out_b_in = level_b_in;
      end

      if (prev_btn_ff && press_ff != PRESS_MAX) begin
         press_in = press_ff + 16'd1;
      end

      if (!prev_btn_ff && req_button_down) begin
         press_in = '0;
      end else if (prev_btn_ff && !req_button_down) begin
         // release: classify with the count that includes this tick
         if (press_in >= setup_min_ff) begin
            setup_in = 1'b1;
         end else if (press_in >= long_min_ff) begin
            preset_in  = next_preset(preset_ff);
            level_a_in = preset_lv.a;
            level_b_in = preset_lv.b;
            out_a_in   = preset_lv.a;
            out_b_in   = preset_lv.b;
            on_in      = 1'b1;
         end else if (press_in < short_limit_ff) begin
            on_in = ~on_ff;
            if (!on_ff) begin
               out_a_in = level_a_in;
               out_b_in = level_b_in;
            end else begin
               out_a_in = '0;
               out_b_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_size_ff   <= STEP_SIZE_RST;
         turn_floor_ff  <= TURN_FLOOR_RST;
         short_limit_ff <= SHORT_LIMIT_RST;
         long_min_ff    <= LONG_MIN_RST;
         setup_min_ff   <= SETUP_MIN_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_STEP_SIZE:   step_size_ff   <= csr_wdata[6:0];
            CSR_TURN_FLOOR:  turn_floor_ff  <= csr_wdata[7:0];
            CSR_SHORT_LIMIT: short_limit_ff <= csr_wdata;
            CSR_LONG_MIN:    long_min_ff    <= csr_wdata;
            CSR_SETUP_MIN:   setup_min_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // tick state doubles as the result word; it only moves when a word is taken,
   // which never happens while a held result is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         level_a_ff   <= LEVEL_RST;
         level_b_ff   <= LEVEL_RST;
         out_a_ff     <= '0;
         out_b_ff     <= '0;
         on_ff        <= 1'b1;
         preset_ff    <= PRESET_WARM;
         press_ff     <= '0;
         prev_btn_ff  <= 1'b0;
         setup_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            level_a_ff  <= level_a_in;
            level_b_ff  <= level_b_in;
            out_a_ff    <= out_a_in;
            out_b_ff    <= out_b_in;
            on_ff       <= on_in;
            preset_ff   <= preset_in;
            press_ff    <= press_in;
            prev_btn_ff <= req_button_down;
            setup_ff    <= setup_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_duty_a        = out_a_ff;
   assign rsp_duty_b        = out_b_ff;
   assign rsp_light_on      = on_ff;
   assign rsp_setup_request = setup_ff;

endmodule
`default_nettype wire
